>>> rtl/tmbc_pkg.sv
package tmbc_pkg;

  localparam int unsigned LevelW  = 4;
  localparam int unsigned TimerW  = 14;
  localparam int unsigned CountW  = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 4;
  localparam int unsigned InDataW = 8;
  localparam int unsigned InUserW = 2;
  localparam int unsigned OutW    = 16;
  localparam int unsigned NumSlot = 3;

  localparam logic [LevelW-1:0] LEVEL_MIN = 4'd1;
  localparam logic [LevelW-1:0] LEVEL_MAX = 4'd7;

  // beacon timing in 1 ms ticks
  localparam logic [TimerW-1:0] BCN_START_MS = 14'd500;
  localparam logic [TimerW-1:0] BCN_ON_MS    = 14'd100;
  localparam logic [TimerW-1:0] BCN_DARK1_MS = 14'd4000;
  localparam logic [TimerW-1:0] BCN_DARK2_MS = 14'd10000;
  localparam logic [TimerW-1:0] BCN_DARK3_MS = 14'd1000;

  localparam logic [CountW-1:0] CNT_ONE   = 3'd1;
  localparam logic [CountW-1:0] CNT_TWO   = 3'd2;
  localparam logic [CountW-1:0] CNT_THREE = 3'd3;
  localparam logic [CountW-1:0] CNT_FOUR  = 3'd4;

  typedef enum logic [1:0] {
    CFG_LVL_ONE   = 2'd0,
    CFG_LVL_TWO   = 2'd1,
    CFG_LVL_THREE = 2'd2,
    CFG_LOCK      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CLICK = 2'd1,
    OP_LONG  = 2'd2,
    OP_WAIT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_OFF  = 2'd1,
    CMD_RAMP = 2'd2,
    CMD_ON   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ONE   = 2'd1,
    MODE_TWO   = 2'd2,
    MODE_THREE = 2'd3
  } mode_e;

  // code 3 is never produced and reads as beacon off
  typedef enum logic [1:0] {
    BCN_OFF  = 2'd0,
    BCN_LIT  = 2'd1,
    BCN_DARK = 2'd2,
    BCN_DEAD = 2'd3
  } bcn_e;

  typedef struct packed {
    logic [NumSlot-1:0][LevelW-1:0] levels;
    logic                           lock;
  } cfg_t;

  typedef struct packed {
    mode_e                          mode;
    logic [LevelW-1:0]              level;
    logic [NumSlot-1:0][LevelW-1:0] rem;
    logic                           lock;
    logic                           loaded;
    bcn_e                           phase;
    logic [TimerW-1:0]              timer;
  } state_t;

  typedef struct packed {
    logic       toggled;
    logic       calib;
    logic       batt;
    logic       pwoff;
    mode_e      slot;
    logic       beacon;
    logic       locked;
    mode_e      mode;
    logic [LevelW-1:0] level;
    cmd_e       cmd;
  } result_t;

endpackage

>>> rtl/tmbc_next.sv
module tmbc_next (
  input  tmbc_pkg::state_t                 st_i,
  input  tmbc_pkg::cfg_t                   cfg_i,
  input  tmbc_pkg::op_e                    op_i,
  input  logic [tmbc_pkg::CountW-1:0]      cnt_i,
  output tmbc_pkg::state_t                 st_o,
  output tmbc_pkg::result_t                res_o
);

  tmbc_pkg::state_t  n;
  tmbc_pkg::result_t r;
  logic              off_pend;
  logic              four_click;
  logic              evt;
  logic [1:0]        slot_idx;

  always_comb begin
    n          = st_i;
    r          = '0;
    r.cmd      = tmbc_pkg::CMD_NONE;
    r.slot     = tmbc_pkg::MODE_OFF;
    off_pend   = 1'b0;
    slot_idx   = 2'(st_i.mode) - 2'd1;
    four_click = (op_i == tmbc_pkg::OP_CLICK) && (cnt_i == tmbc_pkg::CNT_FOUR);
    evt = ((op_i == tmbc_pkg::OP_CLICK) && (cnt_i >= tmbc_pkg::CNT_ONE) &&
           (cnt_i <= tmbc_pkg::CNT_THREE)) ||
          ((op_i == tmbc_pkg::OP_LONG) &&
           ((cnt_i == tmbc_pkg::CNT_ONE) || (cnt_i == tmbc_pkg::CNT_TWO)));

    // first item after reset picks up the stored levels and lock
    if (!st_i.loaded) begin
      n.rem  = cfg_i.levels;
      n.lock = cfg_i.lock;
    end
    n.loaded = 1'b1;

    if (op_i == tmbc_pkg::OP_TICK) begin
      if (n.timer != '0) n.timer = n.timer - 14'd1;
    end else if (op_i == tmbc_pkg::OP_WAIT) begin
      if (n.phase != tmbc_pkg::BCN_OFF) begin
        n.phase = tmbc_pkg::BCN_OFF;
        r.cmd   = tmbc_pkg::CMD_RAMP;
      end
    end else if (four_click) begin
      if (n.mode == tmbc_pkg::MODE_OFF) begin
        n.lock    = ~n.lock;
        r.toggled = 1'b1;
        off_pend  = 1'b1;
      end else begin
        n.rem[slot_idx] = n.level;
        r.slot          = n.mode;
        r.cmd           = tmbc_pkg::CMD_ON;
      end
    end else if (evt) begin
      if (n.lock) begin
        off_pend = 1'b1;
      end else if (op_i == tmbc_pkg::OP_CLICK && cnt_i == tmbc_pkg::CNT_ONE) begin
        if (n.mode == tmbc_pkg::MODE_OFF) begin
          n.mode  = tmbc_pkg::MODE_ONE;
          n.level = n.rem[0];
          r.cmd   = tmbc_pkg::CMD_RAMP;
        end else begin
          if (n.mode == tmbc_pkg::MODE_ONE) n.rem[0] = n.level;
          off_pend = 1'b1;
        end
      end else if (op_i == tmbc_pkg::OP_CLICK && cnt_i == tmbc_pkg::CNT_TWO) begin
        if (n.mode == tmbc_pkg::MODE_OFF) begin
          n.mode  = tmbc_pkg::MODE_THREE;
          n.level = n.rem[2];
          r.cmd   = tmbc_pkg::CMD_RAMP;
        end else if (n.level > tmbc_pkg::LEVEL_MIN) begin
          n.level = n.level - 4'd1;
          r.cmd   = tmbc_pkg::CMD_RAMP;
        end
      end else if (op_i == tmbc_pkg::OP_CLICK) begin
        if (n.mode == tmbc_pkg::MODE_OFF) begin
          r.batt   = 1'b1;
          off_pend = 1'b1;
        end else begin
          r.cmd   = tmbc_pkg::CMD_OFF;
          n.phase = tmbc_pkg::BCN_DARK;
          n.timer = tmbc_pkg::BCN_START_MS;
        end
      end else if (cnt_i == tmbc_pkg::CNT_ONE) begin
        if (n.mode == tmbc_pkg::MODE_OFF) begin
          n.mode  = tmbc_pkg::MODE_TWO;
          n.level = n.rem[1];
          r.cmd   = tmbc_pkg::CMD_RAMP;
        end else if (n.level < tmbc_pkg::LEVEL_MAX) begin
          n.level = n.level + 4'd1;
          r.cmd   = tmbc_pkg::CMD_RAMP;
        end
      end else begin
        if (n.mode == tmbc_pkg::MODE_OFF) begin
          r.calib  = 1'b1;
          off_pend = 1'b1;
        end else if (n.level > tmbc_pkg::LEVEL_MIN) begin
          n.level = n.level - 4'd1;
          r.cmd   = tmbc_pkg::CMD_RAMP;
        end
      end
    end

    // beacon step: once the timer has run out and no switch-off is pending, advances the beacon
    if (!off_pend && n.timer == '0 &&
        (n.phase == tmbc_pkg::BCN_LIT || n.phase == tmbc_pkg::BCN_DARK)) begin
      if (n.mode == tmbc_pkg::MODE_OFF) begin
        n.phase = tmbc_pkg::BCN_OFF;
      end else if (n.phase == tmbc_pkg::BCN_LIT) begin
        r.cmd   = tmbc_pkg::CMD_OFF;
        n.phase = tmbc_pkg::BCN_DARK;
        case (n.mode)
          tmbc_pkg::MODE_ONE: n.timer = tmbc_pkg::BCN_DARK1_MS;
          tmbc_pkg::MODE_TWO: n.timer = tmbc_pkg::BCN_DARK2_MS;
          default:            n.timer = tmbc_pkg::BCN_DARK3_MS;
        endcase
      end else begin
        r.cmd   = tmbc_pkg::CMD_ON;
        n.phase = tmbc_pkg::BCN_LIT;
        n.timer = tmbc_pkg::BCN_ON_MS;
      end
    end
    if (n.phase == tmbc_pkg::BCN_DEAD) n.phase = tmbc_pkg::BCN_OFF;

    // switch-off wins over everything, level is kept
    if (off_pend) begin
      r.cmd   = tmbc_pkg::CMD_OFF;
      n.mode  = tmbc_pkg::MODE_OFF;
      n.phase = tmbc_pkg::BCN_OFF;
      n.timer = '0;
      r.pwoff = 1'b1;
    end

    r.level  = n.level;
    r.mode   = n.mode;
    r.locked = n.lock;
    r.beacon = (n.phase != tmbc_pkg::BCN_OFF);
  end

  assign st_o  = n;
  assign res_o = r;

endmodule

>>> rtl/torch_mode_and_beacon_controller.sv
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[2:0] press_count, tuser[1:0] operation
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[15:0] result fields
// cfg       in   cfg_we_i (no stall)          cfg_index_i, cfg_data_i
//
// One item per cycle while s_axis_tready is high; each result is registered in the output stage.
// The state update is a single combinational pass between the input handshake
// and the result register; a two-entry output stage (result + skid) keeps
// s_axis_tready high while one result waits, and drops it only when both are full.
// Reset clears mode, level, lock, beacon and the load flag; the stored levels
// and lock are taken from the config registers on the first item.
module torch_mode_and_beacon_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tmbc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [tmbc_pkg::CfgW-1:0]       cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tmbc_pkg::InDataW-1:0]    s_axis_tdata,  // [2:0] press_count, rest zero
  input  logic [tmbc_pkg::InUserW-1:0]    s_axis_tuser,  // [1:0] operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] led_command, [5:2] led_level, [7:6] mode_now, [8] locked_now,
  // [9] beacon_active, [11:10] save_slot, [12] power_off_request,
  // [13] battery_report_request, [14] calibration_request, [15] lock_toggled
  output logic [tmbc_pkg::OutW-1:0]       m_axis_tdata
);

  tmbc_pkg::cfg_t    cfg_q;
  tmbc_pkg::state_t  st_q, st_d;
  tmbc_pkg::result_t res;
  logic [tmbc_pkg::OutW-1:0] res_bits;
  logic [tmbc_pkg::OutW-1:0] out_q, skid_q;
  logic              out_vld_q, skid_vld_q;
  logic              acc, take;

  // config registers, reset to the factory defaults
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.levels[0] <= 4'd3;
      cfg_q.levels[1] <= 4'd5;
      cfg_q.levels[2] <= 4'd1;
      cfg_q.lock      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (tmbc_pkg::cfg_idx_e'(cfg_index_i))
        tmbc_pkg::CFG_LVL_ONE:   cfg_q.levels[0] <= cfg_data_i;
        tmbc_pkg::CFG_LVL_TWO:   cfg_q.levels[1] <= cfg_data_i;
        tmbc_pkg::CFG_LVL_THREE: cfg_q.levels[2] <= cfg_data_i;
        tmbc_pkg::CFG_LOCK:      cfg_q.lock      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tmbc_next u_next (
    .st_i  (st_q),
    .cfg_i (cfg_q),
    .op_i  (tmbc_pkg::op_e'(s_axis_tuser)),
    .cnt_i (s_axis_tdata[tmbc_pkg::CountW-1:0]),
    .st_o  (st_d),
    .res_o (res)
  );

  assign res_bits      = res;
  assign s_axis_tready = !skid_vld_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign take          = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode   <= tmbc_pkg::MODE_OFF;
      st_q.level  <= '0;
      st_q.rem    <= '0;
      st_q.lock   <= 1'b0;
      st_q.loaded <= 1'b0;
      st_q.phase  <= tmbc_pkg::BCN_OFF;
      st_q.timer  <= '0;
    end else if (acc) begin
      st_q.mode   <= st_d.mode;
      st_q.level  <= st_d.level;
      st_q.rem    <= st_d.rem;
      st_q.lock   <= st_d.lock;
      st_q.loaded <= st_d.loaded;
      st_q.phase  <= st_d.phase;
      st_q.timer  <= st_d.timer;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (take) begin
        if (skid_vld_q) begin
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= acc;
        end
      end else if (acc) begin
        if (!out_vld_q) out_vld_q <= 1'b1;
        else            skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_vld_q) out_q <= skid_q;
      else if (acc)   out_q <= res_bits;
    end else if (acc) begin
      if (!out_vld_q) out_q  <= res_bits;
      else            skid_q <= res_bits;
    end
  end

endmodule

>>> rtl/tmbc_checker.sv
module tmbc_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [tmbc_pkg::OutW-1:0] m_axis_tdata
);

  // hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // power cut always comes with the LED off and mode off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[12] |->
      m_axis_tdata[1:0] == tmbc_pkg::CMD_OFF && m_axis_tdata[7:6] == tmbc_pkg::MODE_OFF)
    else $error("power off request without switch-off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[7:6] != tmbc_pkg::MODE_OFF)
    else $error("beacon running while off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11:10] != tmbc_pkg::MODE_OFF |->
      m_axis_tdata[11:10] == m_axis_tdata[7:6] && m_axis_tdata[1:0] == tmbc_pkg::CMD_ON)
    else $error("save slot does not match mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[15] || m_axis_tdata[13] || m_axis_tdata[14]) |->
      m_axis_tdata[12])
    else $error("off-state action without power off request");

endmodule

bind torch_mode_and_beacon_controller tmbc_checker u_tmbc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
